FILE: hdl/pip_pkg.sv
package pip_pkg;

  // Width of one coordinate and of the values derived from it.
  localparam int COORD_BITS = 24;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int SUM_W      = PROD_W + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [SUM_W-1:0]      sum_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // Directed edge from a to b.
  typedef struct packed {
    point_t a;
    point_t b;
  } seg_t;

  // Registered products of one edge test.
  typedef struct packed {
    prod_t lhs;       // (bx - ax) * (qy - ay)
    prod_t rhs;       // (qx - ax) * (by - ay)
    prod_t dot_x;     // (qx - ax) * (qx - bx)
    prod_t dot_y;     // (qy - ay) * (qy - by)
    logic  straddle;  // edge crosses the horizontal line through q
    logic  dy_pos;    // by > ay
  } edge_prod_t;

  typedef struct packed {
    logic hit;
    logic toggle;
  } edge_flag_t;

  // Control that travels with an item through the pipeline.
  typedef struct packed {
    logic en1;    // edge from the previous vertex is tested
    logic en2;    // closing edge back to the first vertex is tested
    logic first;  // item opens a new polygon
    logic last;   // item closes the polygon and yields a result
  } stage_ctl_t;

endpackage

FILE: hdl/pip_if.sv
interface pip_in_if import pip_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t query_x;
  coord_t query_y;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (
    output valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, query_x, query_y, vertex_x, vertex_y, last_vertex,
    output ready
  );
endinterface

interface pip_out_if ();
  logic valid;
  logic ready;
  logic inside_res;
  logic on_boundary;

  modport source (
    output valid, inside_res, on_boundary,
    input  ready
  );
  modport sink (
    input  valid, inside_res, on_boundary,
    output ready
  );
endinterface

FILE: hdl/pip_edge_prod.sv
module pip_edge_prod import pip_pkg::*; (
  input  logic       clk_i,
  input  logic       load_i,
  input  point_t     q_i,
  input  seg_t       seg_i,
  output edge_prod_t prod_o
);

  diff_t      dx_ba, dy_ba, qx_a, qy_a, qx_b, qy_b;
  edge_prod_t prod_d, prod_q;

  always_comb begin
    dx_ba = DIFF_W'(seg_i.b.x) - DIFF_W'(seg_i.a.x);
    dy_ba = DIFF_W'(seg_i.b.y) - DIFF_W'(seg_i.a.y);
    qx_a  = DIFF_W'(q_i.x) - DIFF_W'(seg_i.a.x);
    qy_a  = DIFF_W'(q_i.y) - DIFF_W'(seg_i.a.y);
    qx_b  = DIFF_W'(q_i.x) - DIFF_W'(seg_i.b.x);
    qy_b  = DIFF_W'(q_i.y) - DIFF_W'(seg_i.b.y);

    prod_d.lhs      = PROD_W'(dx_ba) * PROD_W'(qy_a);
    prod_d.rhs      = PROD_W'(qx_a) * PROD_W'(dy_ba);
    prod_d.dot_x    = PROD_W'(qx_a) * PROD_W'(qx_b);
    prod_d.dot_y    = PROD_W'(qy_a) * PROD_W'(qy_b);
    prod_d.straddle = (seg_i.a.y > q_i.y) != (seg_i.b.y > q_i.y);
    prod_d.dy_pos   = seg_i.b.y > seg_i.a.y;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/pip_edge_eval.sv
module pip_edge_eval import pip_pkg::*; (
  input  edge_prod_t prod_i,
  input  logic       en_i,
  output edge_flag_t flag_o
);

  sum_t cross_val, dot;
  logic hit, right;

  always_comb begin
    cross_val = SUM_W'(prod_i.lhs) - SUM_W'(prod_i.rhs);
    dot       = SUM_W'(prod_i.dot_x) + SUM_W'(prod_i.dot_y);
    hit       = (cross_val == '0) && (dot <= 0);
    // The intersection lies at or right of q; the sign of dy flips the compare.
    right = prod_i.dy_pos ? (prod_i.lhs >= prod_i.rhs) : (prod_i.lhs <= prod_i.rhs);
    flag_o.hit    = en_i && hit;
    flag_o.toggle = en_i && !hit && prod_i.straddle && right;
  end

endmodule

FILE: hdl/point_in_polygon_test.sv
// Path: after its last vertex is accepted, the result of a polygon moves through the input stage,
//   the product stage and then the result register, which drives res_o.
// Throughput: one vertex transaction per cycle, limited only by downstream backpressure.
// Reset: rst_ni is asynchronous and active low; it empties the pipeline and the result
//   register and leaves the block waiting for the first vertex of a polygon.
module point_in_polygon_test import pip_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pip_in_if.sink    vtx_i,
  pip_out_if.source res_o
);

  // Polygon tracking state, updated as each vertex transaction is accepted.
  logic   mid_q;
  point_t held_q, start_q, prior_q;

  // Stage A: the item with its query point and both candidate edges.
  logic       a_vld_q;
  point_t     a_pt_q;
  seg_t       a_e1_q, a_e2_q;
  stage_ctl_t a_ctl_q;

  // Stage B: products of both edges live in the product units.
  logic       b_vld_q;
  stage_ctl_t b_ctl_q;
  edge_prod_t prod1, prod2;
  edge_flag_t flag1, flag2;

  // Running crossing parity and boundary hit of the polygon in progress.
  logic parity_q, hit_q, parity_d, hit_d;

  // Result register.
  logic out_vld_q, inside_q, bound_q;

  logic   acc, a_adv, b_adv, a_free, b_free, out_free;
  point_t cur_v, cur_q, cur_start;

  // Backpressure. Items that do not close a polygon leave stage B without touching
  // the result register, so only a last vertex can stall behind a waiting result.
  assign out_free    = !out_vld_q || res_o.ready;
  assign b_adv       = b_vld_q && (!b_ctl_q.last || out_free);
  assign b_free      = !b_vld_q || b_adv;
  assign a_adv       = a_vld_q && b_free;
  assign a_free      = !a_vld_q || a_adv;
  assign vtx_i.ready = a_free;
  assign acc         = vtx_i.valid && vtx_i.ready;

  // The query point and the first vertex are captured when a polygon opens.
  always_comb begin
    cur_v.x   = vtx_i.vertex_x;
    cur_v.y   = vtx_i.vertex_y;
    cur_q     = held_q;
    cur_start = start_q;
    if (!mid_q) begin
      cur_q.x   = vtx_i.query_x;
      cur_q.y   = vtx_i.query_y;
      cur_start = cur_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= 1'b0;
    end else if (acc) begin
      mid_q <= !vtx_i.last_vertex;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      held_q  <= cur_q;
      start_q <= cur_start;
      prior_q <= cur_v;
    end
  end

  // Stage A register. The first edge runs from the previous vertex to this one and
  // exists only inside a polygon; the closing edge exists only on the last vertex.
  // For a single-vertex polygon the closing edge collapses to one point.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (a_free) begin
      a_vld_q <= vtx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_pt_q        <= cur_q;
      a_e1_q.a      <= prior_q;
      a_e1_q.b      <= cur_v;
      a_e2_q.a      <= cur_v;
      a_e2_q.b      <= cur_start;
      a_ctl_q.en1   <= mid_q;
      a_ctl_q.en2   <= vtx_i.last_vertex;
      a_ctl_q.first <= !mid_q;
      a_ctl_q.last  <= vtx_i.last_vertex;
    end
  end

  // Stage B: differences and products for both edges, registered in the units.
  pip_edge_prod u_prod1 (
    .clk_i  (clk_i),
    .load_i (a_adv),
    .q_i    (a_pt_q),
    .seg_i  (a_e1_q),
    .prod_o (prod1)
  );

  pip_edge_prod u_prod2 (
    .clk_i  (clk_i),
    .load_i (a_adv),
    .q_i    (a_pt_q),
    .seg_i  (a_e2_q),
    .prod_o (prod2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (b_free) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_ctl_q <= a_ctl_q;
    end
  end

  // Stage C: compares on the registered products, then the one-bit accumulation.
  pip_edge_eval u_eval1 (
    .prod_i (prod1),
    .en_i   (b_ctl_q.en1),
    .flag_o (flag1)
  );

  pip_edge_eval u_eval2 (
    .prod_i (prod2),
    .en_i   (b_ctl_q.en2),
    .flag_o (flag2)
  );

  // A new polygon starts from clear parity and hit bits.
  always_comb begin
    parity_d = (parity_q && !b_ctl_q.first) ^ flag1.toggle ^ flag2.toggle;
    hit_d    = (hit_q && !b_ctl_q.first) || flag1.hit || flag2.hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_q <= 1'b0;
      hit_q    <= 1'b0;
    end else if (b_adv) begin
      parity_q <= parity_d;
      hit_q    <= hit_d;
    end
  end

  // Result register: loaded when a closing vertex leaves stage B.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= (out_vld_q && !res_o.ready) || (b_adv && b_ctl_q.last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_ctl_q.last) begin
      inside_q <= hit_d || parity_d;
      bound_q  <= hit_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.inside_res  = inside_q;
  assign res_o.on_boundary = bound_q;

endmodule

FILE: hdl/pip_checker.sv
module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic in_last,
  input logic out_valid,
  input logic out_ready,
  input logic out_inside,
  input logic out_bound
);

  // Polygons closed at the input whose results have not yet been delivered.
  logic [2:0] pend_q;
  logic       in_close, out_take;

  assign in_close = in_valid && in_ready && in_last;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(in_close) - 3'(out_take);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_inside) && $stable(out_bound))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pend_q != 3'd0)
    else $error("result without a closed polygon");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more polygons in flight than pipeline stages");

  a_bound_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_bound |-> out_inside)
    else $error("boundary point not reported inside");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (vtx_i.valid),
  .in_ready   (vtx_i.ready),
  .in_last    (vtx_i.last_vertex),
  .out_valid  (res_o.valid),
  .out_ready  (res_o.ready),
  .out_inside (res_o.inside_res),
  .out_bound  (res_o.on_boundary)
);
